// File: hdl/emhq_pkg.sv
package emhq_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  // child index can reach 2*DEPTH, one bit more than the count
  localparam int IDX_W  = CNT_W + 1;
  localparam int KEY_W  = 32;
  localparam int OCC_W  = 7;

  typedef logic [KEY_W-1:0]  key_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_CMP,
    S_DN_LOAD,
    S_DN_CMP,
    S_WR_FIN,
    S_DONE
  } state_t;

endpackage

// File: hdl/emhq_ram.sv
module emhq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/event_min_heap_queue.sv
// channel   | handshake            | payload
// ----------+----------------------+------------------------------------------------
// request   | in_valid / in_ready  | in_cmd, in_time, in_process, in_thread
// result    | out_valid / out_ready| out_status, out_time, out_process, out_thread,
//           |                      | out_occupancy
//
// push: one compare per level on the way up (each level climbed, and the
// compare that stops the climb), then the final write; pop: a load of the root
// and last entry, one compare per level on the way down, then the final write.
// each level costs one read/compare/write pass through the key store (two copies,
// one read port each, so both children come back in the same cycle).
// rst_n clears the count and control; the key store is not cleared.
// a new request is taken only in idle; a finished result waits in the output
// register and the next request is taken while it is unread.
module event_min_heap_queue
  import emhq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [15:0] in_time,
  input  logic [7:0]  in_process,
  input  logic [7:0]  in_thread,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [15:0] out_time,
  output logic [7:0]  out_process,
  output logic [7:0]  out_thread,
  output logic [6:0]  out_occupancy
);

  state_t  state_r, state_nxt;
  cnt_t    cnt_r, cnt_nxt;
  addr_t   pos_r, pos_nxt;
  key_t    key_r, key_nxt;
  key_t    pop_r, pop_nxt;
  status_t status_r, status_nxt;

  logic             out_valid_r, out_valid_nxt;
  status_t          out_status_r, out_status_nxt;
  key_t             out_key_r, out_key_nxt;
  logic [OCC_W-1:0] out_occ_r, out_occ_nxt;

  logic  we;
  addr_t waddr, raddr_a, raddr_b;
  key_t  wdata, rdata_a, rdata_b;

  logic  in_fire, full, empty, handover;
  key_t  in_key;
  addr_t push_pos, push_par, up_par, up_par2, last_pos;
  logic  up_stop;
  idx_t  left_i, right_i, nl_i, nr_i;
  logic  left_ok, right_ok, l_less, r_less, moved, nl_ok;
  key_t  small_val, child_val;
  addr_t child_addr;

  emhq_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_a),
    .rdata (rdata_a)
  );

  emhq_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr_b),
    .rdata (rdata_b)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign in_key   = {in_time, in_process, in_thread};
  assign full     = (cnt_r == cnt_t'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign handover = !out_valid_r || out_ready;

  // sift up
  assign push_pos = cnt_r[ADDR_W-1:0];
  assign push_par = (push_pos - addr_t'(1)) >> 1;
  assign up_par   = (pos_r - addr_t'(1)) >> 1;
  assign up_par2  = (up_par - addr_t'(1)) >> 1;
  assign up_stop  = (rdata_a <= key_r);
  assign last_pos = addr_t'(cnt_r - cnt_t'(1));

  // sift down: children of pos_r, bounded by the count
  assign left_i     = idx_t'({pos_r, 1'b1});
  assign right_i    = left_i + idx_t'(1);
  assign left_ok    = left_i < idx_t'(cnt_r);
  assign right_ok   = right_i < idx_t'(cnt_r);
  assign l_less     = left_ok && (rdata_a < key_r);
  assign small_val  = l_less ? rdata_a : key_r;
  assign r_less     = right_ok && (rdata_b < small_val);
  assign moved      = l_less || r_less;
  assign child_addr = r_less ? right_i[ADDR_W-1:0] : left_i[ADDR_W-1:0];
  assign child_val  = r_less ? rdata_b : rdata_a;
  assign nl_i       = idx_t'({child_addr, 1'b1});
  assign nr_i       = nl_i + idx_t'(1);
  assign nl_ok      = nl_i < idx_t'(cnt_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_cmd == CMD_PUSH) begin
            priority if (full)            state_nxt = S_DONE;
            else if (push_pos == '0)      state_nxt = S_WR_FIN;
            else                          state_nxt = S_UP_CMP;
          end else begin
            state_nxt = empty ? S_DONE : S_DN_LOAD;
          end
        end
      end
      S_UP_CMP: begin
        if (up_stop || up_par == '0) state_nxt = S_WR_FIN;
      end
      S_DN_LOAD: begin
        state_nxt = (idx_t'(1) < idx_t'(cnt_r)) ? S_DN_CMP : S_WR_FIN;
      end
      S_DN_CMP: begin
        if (!moved || !nl_ok) state_nxt = S_WR_FIN;
      end
      S_WR_FIN: state_nxt = S_DONE;
      S_DONE: begin
        if (handover) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cnt_nxt        = cnt_r;
    pos_nxt        = pos_r;
    key_nxt        = key_r;
    pop_nxt        = pop_r;
    status_nxt     = status_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_key_nxt    = out_key_r;
    out_occ_nxt    = out_occ_r;
    we             = 1'b0;
    waddr          = pos_r;
    wdata          = key_r;
    raddr_a        = '0;
    raddr_b        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          key_nxt    = in_key;
          pop_nxt    = '0;
          status_nxt = ST_OK;
          if (in_cmd == CMD_PUSH) begin
            if (full) begin
              status_nxt = ST_FULL;
            end else begin
              cnt_nxt = cnt_r + cnt_t'(1);
              pos_nxt = push_pos;
              raddr_a = push_par;
            end
          end else begin
            if (empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              // root on port a, last entry on port b
              cnt_nxt = cnt_r - cnt_t'(1);
              raddr_b = last_pos;
            end
          end
        end
      end
      S_UP_CMP: begin
        if (!up_stop) begin
          we      = 1'b1;
          wdata   = rdata_a;
          pos_nxt = up_par;
          raddr_a = up_par2;
        end
      end
      S_DN_LOAD: begin
        pop_nxt = rdata_a;
        key_nxt = rdata_b;
        pos_nxt = '0;
        raddr_a = addr_t'(1);
        raddr_b = addr_t'(2);
      end
      S_DN_CMP: begin
        if (moved) begin
          we      = 1'b1;
          wdata   = child_val;
          pos_nxt = child_addr;
          raddr_a = nl_i[ADDR_W-1:0];
          raddr_b = nr_i[ADDR_W-1:0];
        end
      end
      S_WR_FIN: begin
        we = 1'b1;
      end
      S_DONE: begin
        if (handover) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = status_r;
          out_key_nxt    = pop_r;
          out_occ_nxt    = OCC_W'(cnt_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pos_r        <= pos_nxt;
    key_r        <= key_nxt;
    pop_r        <= pop_nxt;
    status_r     <= status_nxt;
    out_status_r <= out_status_nxt;
    out_key_r    <= out_key_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_time      = out_key_r[31:16];
  assign out_process   = out_key_r[15:8];
  assign out_thread    = out_key_r[7:0];
  assign out_occupancy = out_occ_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= cnt_t'(DEPTH))
    else $error("entry count above depth");

  a_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_cmd == CMD_POP && empty |=> state_r == S_DONE && status_r == ST_EMPTY)
    else $error("pop on empty queue not refused");

  a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_cmd == CMD_PUSH && !full |=> cnt_r == cnt_t'($past(cnt_r) + cnt_t'(1)))
    else $error("push did not bump count");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> state_r != S_IDLE && state_r != S_DONE)
    else $error("key store written outside an operation");

  a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_OK |-> out_key_r == '0)
    else $error("refused request carries a key");

endmodule
